// ===== rtl/npc_pkg.sv =====
// Shared types, constants and helpers for the nearest palette color core.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package npc_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int COUNT_W          = 9;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DIST_W           = 18;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] entry_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic       is_pixel;
        logic       wr_ok;
        logic [7:0] index;
        t_rgb       color;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/npc_front.sv =====
// Front stage: registers each accepted word and classifies it as a palette
// load or a pixel lookup. Depends on npc_pkg.
`default_nettype none

module npc_front
    import npc_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_pix_in i_in_data,
    input  wire logic    i_q_full,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign o_in_stall = r_vld && i_q_full;
    assign take       = i_in_valid && !o_in_stall;
    assign o_push     = r_vld && !i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.is_pixel    = (i_in_data.mode == MODE_PIXEL);
        n_cmd.wr_ok       = (32'(i_in_data.entry_index) < 32'(PALETTE_SIZE));
        n_cmd.index       = i_in_data.entry_index;
        n_cmd.color.red   = i_in_data.red_in;
        n_cmd.color.green = i_in_data.green_in;
        n_cmd.color.blue  = i_in_data.blue_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/npc_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
// Depends on npc_pkg.
`default_nettype none

module npc_queue
    import npc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output t_hs       o_hs,
    input  wire logic i_pop_ready,
    output t_cmd      o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;
    logic            pop;

    assign o_full       = (r_count == (PW + 1)'(QUEUE_DEPTH));
    assign o_hs.valid   = (r_count != '0);
    assign o_hs.ready   = i_pop_ready;
    assign pop          = o_hs.valid && i_pop_ready;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/npc_back.sv =====
// Back end: palette memory, the scan pipeline that finds the nearest entry,
// the palette count register and the output register. Depends on npc_pkg.
`default_nettype none

module npc_back
    import npc_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_hs                i_q_hs,
    input  wire t_cmd               i_q_cmd,
    output logic                    o_pop_ready,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_pix_out                o_out_data
);

    localparam int AW = $clog2(PALETTE_SIZE);
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam logic [CW-1:0] SIZE_C = CW'(PALETTE_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [COUNT_W-1:0]  r_palette_count;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       n_addr;
    logic [AW-1:0]       r_last;
    logic [AW-1:0]       n_last;
    t_rgb                r_pix;
    t_rgb                r_mem [PALETTE_SIZE];

    logic                r_s1_vld;
    logic                r_s1_first;
    logic                r_s1_last;
    t_rgb                r_s1_color;

    logic                r_s2_vld;
    logic                r_s2_first;
    logic                r_s2_last;
    t_rgb                r_s2_color;
    logic [15:0]         r_sq_r;
    logic [15:0]         r_sq_g;
    logic [15:0]         r_sq_b;

    logic [DIST_W-1:0]   r_best_dist;
    t_rgb                r_best_color;
    logic                r_done;

    logic                r_out_vld;
    t_pix_out            r_out;

    logic                pop;
    logic                wr_en;
    logic                start;
    logic                issue;
    logic                out_free;
    logic                out_load;
    logic [CW-1:0]       cnt_ext;
    logic [DIST_W-1:0]   sum;
    logic [7:0]          d_r;
    logic [7:0]          d_g;
    logic [7:0]          d_b;

    assign o_cfg_ready = 1'b1;
    assign o_pop_ready = (r_state == ST_IDLE);
    assign pop         = i_q_hs.valid && i_q_hs.ready;
    assign wr_en       = pop && !i_q_cmd.is_pixel && i_q_cmd.wr_ok;
    assign start       = pop && i_q_cmd.is_pixel;
    assign issue       = (r_state == ST_SCAN);
    assign out_free    = !r_out_vld || !i_out_stall;
    assign out_load    = (r_state == ST_FINISH) && r_done && out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        cnt_ext = CW'(r_palette_count);
        if (cnt_ext == '0) begin
            n_last = '0;
        end else if (cnt_ext > SIZE_C) begin
            n_last = AW'(SIZE_C - 1'b1);
        end else begin
            n_last = AW'(cnt_ext - 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                end
            end
            ST_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_palette_count <= COUNT_W'(1);
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_done          <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_palette_count <= i_cfg_data;
            end
            if (r_s2_vld && r_s2_last) begin
                r_done <= 1'b1;
            end else if (out_load) begin
                r_done <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(i_q_cmd.index)] <= i_q_cmd.color;
        end
        r_s1_color <= r_mem[r_addr];
    end

    always_comb begin
        d_r = abs_diff(r_s1_color.red, r_pix.red);
        d_g = abs_diff(r_s1_color.green, r_pix.green);
        d_b = abs_diff(r_s1_color.blue, r_pix.blue);
        sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (start) begin
            r_pix  <= i_q_cmd.color;
            r_last <= n_last;
        end
        r_s1_first <= (r_addr == '0);
        r_s1_last  <= (r_addr == r_last);

        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_color <= r_s1_color;
        r_sq_r     <= 16'(d_r) * 16'(d_r);
        r_sq_g     <= 16'(d_g) * 16'(d_g);
        r_sq_b     <= 16'(d_b) * 16'(d_b);

        if (r_s2_vld && (r_s2_first || (sum < r_best_dist))) begin
            r_best_dist  <= sum;
            r_best_color <= r_s2_color;
        end

        if (out_load) begin
            r_out.red_out   <= r_best_color.red;
            r_out.green_out <= r_best_color.green;
            r_out.blue_out  <= r_best_color.blue;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nearest_palette_color_core.sv =====
// A load is registered by the front stage and queued before the back end writes it into the
// palette; a pixel result is offered after the one-entry-per-cycle scan has covered the palette.
// One load per cycle while the back end is idle; it is busy until each pixel result is registered.
// Reset is synchronous and active low; it clears control state and sets the
// palette count to 1. Palette contents are undefined until written.
`default_nettype none

module nearest_palette_color_core
    import npc_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_pix_in            i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_pix_out                o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COUNT_W-1:0] i_cfg_data
);

    logic q_full;
    logic push;
    logic pop_ready;
    t_cmd front_cmd;
    t_cmd q_cmd;
    t_hs  q_hs;

    npc_front #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    npc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (q_full),
        .o_hs        (q_hs),
        .i_pop_ready (pop_ready),
        .o_cmd       (q_cmd)
    );

    npc_back #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_hs      (q_hs),
        .i_q_cmd     (q_cmd),
        .o_pop_ready (pop_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/npc_checker.sv =====
// Port-level checks for the nearest palette color core, bound to the top level.
// Depends on npc_pkg.
`default_nettype none

module npc_checker
    import npc_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_stall,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_pix_out o_out_data,
    input wire logic     o_cfg_ready
);

    // A result that is held back must stay offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result word changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && o_cfg_ready)
        else $error("input or configuration blocked right after reset");

endmodule

bind nearest_palette_color_core npc_checker u_npc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
